// ===== rtl/bmm_pkg.sv =====
`timescale 1ns / 1ps
package bmm_pkg;

  localparam int JOB_LANES            = 16;
  localparam int JOB_W                = 4;
  localparam int STACK_SLOTS          = JOB_LANES + 1;
  localparam int SP_W                 = 5;
  localparam int CNT_W                = 5;
  localparam int DEFAULT_MAX_VERTICES = 16;
  localparam logic [CNT_W-1:0] JOB_COUNT_RESET = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_ROOT,
    ST_SCAN,
    ST_PUSH,
    ST_POP,
    ST_ROLL,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ROOT,
    OP_SCAN,
    OP_PUSH,
    OP_POP,
    OP_ROLL,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t  op;
    logic row_wr;
  } cmd_t;

  typedef struct packed {
    logic more_workers;
    logic cand_any;
    logic job_free;
    logic sp_one;
    logic stack_full;
    logic out_free;
  } status_t;

  // index of the lowest set bit, zero when none
  function automatic logic [JOB_W-1:0] lowest_bit(input logic [JOB_LANES-1:0] v);
    logic [JOB_W-1:0] idx;
    idx = '0;
    for (int i = JOB_LANES - 1; i >= 0; i--) begin
      if (v[i]) idx = JOB_W'(i);
    end
    return idx;
  endfunction

endpackage

// ===== rtl/bipartite_max_matching_core.sv =====
`timescale 1ns / 1ps
// maximum bipartite matching core (augmenting-path search, explicit stack)
// s_axis: one worker row per transfer; tdata bit j set when the worker can do
//   job j, tlast marks the final row and starts the search
// m_axis: one transfer per graph carrying the number of matched pairs
// cfg: writes job_count, the number of jobs in use; take it only while idle
// rows load at one per cycle while idle; rows past MAX_VERTICES are dropped,
//   though a dropped last row still starts the search
// after the last row the core runs the search with s_axis_tready low:
//   per worker a start and a root state fetch its row, then each job tried
//   takes a scan state, plus a push, pop or rollback state for each such
//   step; the row memory and stack memory ports (one read per cycle,
//   registered) set this pace; each job is tried at most once per worker
// result passes the done state into the output register; the graph is then
//   cleared and the next row starts a new graph
// a stalled result holds in the output register; new rows are still taken,
//   but the next search waits to hand over its count until it is taken
// reset (rst, synchronous) clears the graph and sets job_count to 16
module bipartite_max_matching_core
  import bmm_pkg::*;
#(
  parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,   // row_bits[15:0]
  input  logic             s_axis_tlast,   // last_row
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // match_count[4:0], zero fill [7:5]
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data        // job_count
);

  cmd_t             cmd;
  status_t          status;
  logic [CNT_W-1:0] out_count;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  bmm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .row_valid (s_axis_tvalid),
    .row_last  (s_axis_tlast),
    .row_ready (s_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  bmm_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .row_bits  (s_axis_tdata),
    .cfg_wr    (cfg_valid),
    .cfg_value (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_count (out_count)
  );

  // result packed in the low bits, zero fill to the byte
  assign m_axis_tdata = {3'b000, out_count};

endmodule

// ===== rtl/bmm_ctrl.sv =====
`timescale 1ns / 1ps
module bmm_ctrl
  import bmm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    row_valid,
  input  logic    row_last,
  output logic    row_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (row_valid && row_last) state_next = ST_START;
      end
      ST_START: begin
        state_next = status.more_workers ? ST_ROOT : ST_DONE;
      end
      ST_ROOT: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!status.cand_any) begin
          state_next = status.sp_one ? ST_START : ST_POP;
        end else if (status.job_free) begin
          state_next = status.sp_one ? ST_START : ST_ROLL;
        end else if (!status.stack_full) begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        state_next = ST_SCAN;
      end
      ST_POP: begin
        state_next = ST_SCAN;
      end
      ST_ROLL: begin
        if (status.sp_one) state_next = ST_START;
      end
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    row_ready  = 1'b0;
    cmd.row_wr = 1'b0;
    cmd.op     = OP_NONE;
    case (state)
      ST_IDLE: begin
        row_ready  = 1'b1;
        cmd.row_wr = row_valid;
      end
      ST_START: cmd.op = OP_NONE;
      ST_ROOT:  cmd.op = OP_ROOT;
      ST_SCAN:  cmd.op = OP_SCAN;
      ST_PUSH:  cmd.op = OP_PUSH;
      ST_POP:   cmd.op = OP_POP;
      ST_ROLL:  cmd.op = OP_ROLL;
      ST_DONE: begin
        if (status.out_free) cmd.op = OP_FINISH;
      end
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

// ===== rtl/bmm_datapath.sv =====
`timescale 1ns / 1ps
module bmm_datapath
  import bmm_pkg::*;
#(
  parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic [JOB_LANES-1:0] row_bits,
  input  logic                 cfg_wr,
  input  logic [CNT_W-1:0]     cfg_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CNT_W-1:0]     out_count
);

  localparam int AW      = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int RW      = $clog2(MAX_VERTICES + 1);
  localparam int JOB_CAP = (MAX_VERTICES < JOB_LANES) ? MAX_VERTICES : JOB_LANES;

  typedef struct packed {
    logic [JOB_LANES-1:0] row;
    logic [AW-1:0]        worker;
    logic [CNT_W-1:0]     next;
    logic [JOB_W-1:0]     job;
  } frame_t;

  // stored adjacency rows
  logic [JOB_LANES-1:0] edge_mem [MAX_VERTICES];
  logic [JOB_LANES-1:0] edge_rd;
  logic [AW-1:0]        edge_rd_addr;

  // search stack
  frame_t               stk_mem [STACK_SLOTS];
  frame_t               stk_rd;
  frame_t               stk_wr_data;
  logic                 stk_wr;
  logic [SP_W-1:0]      stk_rd_addr;
  logic [SP_W-1:0]      stk_wr_addr;

  logic [RW-1:0]        rows_loaded;
  logic [RW-1:0]        worker_idx;
  logic [CNT_W-1:0]     job_count;
  logic [CNT_W-1:0]     jobs_eff;
  logic [CNT_W-1:0]     pairs;
  logic [SP_W-1:0]      sp;
  logic [JOB_LANES-1:0] top_row;
  logic [AW-1:0]        top_worker;
  logic [CNT_W-1:0]     top_next;
  logic [JOB_LANES-1:0] visited;
  logic [JOB_LANES-1:0] owner_valid;
  logic [AW-1:0]        owner [JOB_LANES];

  logic [JOB_LANES-1:0] window;
  logic [JOB_LANES-1:0] cand;
  logic [JOB_W-1:0]     sel_job;
  logic [AW-1:0]        sel_owner;
  logic                 sel_free;
  logic                 sp_one;
  logic                 stack_full;

  assign jobs_eff = (job_count > CNT_W'(JOB_CAP)) ? CNT_W'(JOB_CAP) : job_count;

  always_comb begin
    for (int j = 0; j < JOB_LANES; j++) begin
      window[j] = (CNT_W'(j) >= top_next) && (CNT_W'(j) < jobs_eff);
    end
  end

  assign cand       = top_row & ~visited & window;
  assign sel_job    = lowest_bit(cand);
  assign sel_owner  = owner[sel_job];
  assign sel_free   = !owner_valid[sel_job];
  assign sp_one     = (sp == SP_W'(1));
  assign stack_full = (sp == SP_W'(STACK_SLOTS));

  assign status.more_workers = (worker_idx < rows_loaded);
  assign status.cand_any     = |cand;
  assign status.job_free     = sel_free;
  assign status.sp_one       = sp_one;
  assign status.stack_full   = stack_full;
  assign status.out_free     = !out_valid || out_ready;

  // row memory: write on load, read for a root or a pushed owner
  assign edge_rd_addr = (cmd.op == OP_SCAN) ? sel_owner : worker_idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.row_wr && (rows_loaded < RW'(MAX_VERTICES))) begin
      edge_mem[rows_loaded[AW-1:0]] <= row_bits;
    end
    edge_rd <= edge_mem[edge_rd_addr];
  end

  // stack memory: push writes the current top, pop and rollback read below it
  assign stk_rd_addr        = sp - SP_W'(2);
  assign stk_wr_addr        = sp - SP_W'(1);
  assign stk_wr             = (cmd.op == OP_SCAN) && (|cand) && !sel_free && !stack_full;
  assign stk_wr_data.row    = top_row;
  assign stk_wr_data.worker = top_worker;
  assign stk_wr_data.next   = CNT_W'(sel_job) + CNT_W'(1);
  assign stk_wr_data.job    = sel_job;

  always_ff @(posedge clk) begin
    if (stk_wr) begin
      stk_mem[stk_wr_addr] <= stk_wr_data;
    end
    stk_rd <= stk_mem[stk_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_loaded <= '0;
      worker_idx  <= '0;
      job_count   <= JOB_COUNT_RESET;
      pairs       <= '0;
      sp          <= '0;
      visited     <= '0;
      owner_valid <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr) job_count <= cfg_value;
      if (cmd.op == OP_FINISH) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.row_wr && (rows_loaded < RW'(MAX_VERTICES))) begin
        rows_loaded <= rows_loaded + RW'(1);
      end
      case (cmd.op)
        OP_ROOT: begin
          sp      <= SP_W'(1);
          visited <= '0;
        end
        OP_SCAN: begin
          if (|cand) begin
            visited[sel_job] <= 1'b1;
            if (sel_free) begin
              owner_valid[sel_job] <= 1'b1;
              if (sp_one) begin
                pairs      <= pairs + CNT_W'(1);
                worker_idx <= worker_idx + RW'(1);
              end else begin
                sp <= sp - SP_W'(1);
              end
            end else if (!stack_full) begin
              sp <= sp + SP_W'(1);
            end
          end else if (sp_one) begin
            worker_idx <= worker_idx + RW'(1);
            sp         <= '0;
          end else begin
            sp <= sp - SP_W'(1);
          end
        end
        OP_ROLL: begin
          owner_valid[stk_rd.job] <= 1'b1;
          if (sp_one) begin
            pairs      <= pairs + CNT_W'(1);
            worker_idx <= worker_idx + RW'(1);
          end else begin
            sp <= sp - SP_W'(1);
          end
        end
        OP_FINISH: begin
          rows_loaded <= '0;
          worker_idx  <= '0;
          pairs       <= '0;
          owner_valid <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ROOT: begin
        top_row    <= edge_rd;
        top_worker <= worker_idx[AW-1:0];
        top_next   <= '0;
      end
      OP_SCAN: begin
        if (|cand) begin
          if (sel_free) begin
            owner[sel_job] <= top_worker;
          end
          if (!sel_free && !stack_full) begin
            top_worker <= sel_owner;
            top_next   <= '0;
          end else begin
            top_next <= CNT_W'(sel_job) + CNT_W'(1);
          end
        end
      end
      OP_PUSH: begin
        top_row <= edge_rd;
      end
      OP_POP: begin
        top_row    <= stk_rd.row;
        top_worker <= stk_rd.worker;
        top_next   <= stk_rd.next;
      end
      OP_ROLL: begin
        owner[stk_rd.job] <= stk_rd.worker;
      end
      OP_FINISH: begin
        out_count <= pairs;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/bmm_checker.sv =====
`timescale 1ns / 1ps
module bmm_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // result stays up while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // pair count never exceeds the job lanes
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata <= 8'd16))
    else $error("match count out of range");

  // a new result comes only out of a search, never while rows are taken
  a_result_after_search: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared outside a search");

  // no result right after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind bipartite_max_matching_core bmm_checker u_bmm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
